>>> rtl/core/rbf_pkg.sv
// Package for the reduced Blowfish cipher: constants, constant tables,
// controller/datapath command and status types. No dependencies.
package rbf_pkg;

  // Table sizes and key schedule constants
  localparam int DEF_ROUNDS = 16;
  localparam int SBOX_WORDS = 16;
  localparam int PBOX_WORDS = 3;
  localparam int KEY_REGS   = 7;
  localparam int KEY_MOD    = 57;
  localparam int MIX_WORDS  = 18;
  localparam int S_FILL     = 256;

  // Configuration register indexes
  localparam logic [2:0] CFG_KEY_LEN   = 3'd0;
  localparam logic [2:0] CFG_KEY_FIRST = 3'd1;

  // Initial P and S words
  localparam logic [31:0] INIT_P [PBOX_WORDS] = '{
    32'h243F6A88, 32'h85A308D3, 32'h13198A2E
  };

  localparam logic [31:0] INIT_S [SBOX_WORDS] = '{
    32'hD1310BA6, 32'h98DFB5AC, 32'h2FFD72DB, 32'hD01ADFB7,
    32'hB8E1AFED, 32'h6A267E96, 32'hBA7C9045, 32'hF12C7F99,
    32'h24A19947, 32'hB3916CF7, 32'h0801F2E2, 32'h858EFC16,
    32'h636920D8, 32'h71574E69, 32'hA458FEA3, 32'hF4933D7E
  };

  // Request operation codes
  typedef enum logic [1:0] {
    FN_REKEY = 2'd0,
    FN_ENC   = 2'd1,
    FN_DEC   = 2'd2,
    FN_NONE  = 2'd3
  } func_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_MIX,
    ST_RA,
    ST_RB,
    ST_RC,
    ST_FIN,
    ST_SWR,
    ST_DONE
  } state_t;

  // Datapath operations
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_REKEY_INIT,
    DP_MIX,
    DP_RND_A,
    DP_RND_B,
    DP_RND_C,
    DP_FIN,
    DP_SWR_LO,
    DP_OUT
  } dp_op_t;

  // Where the result of a chained encryption goes during rekey
  typedef enum logic [1:0] {
    FILL_NONE,
    FILL_P,
    FILL_S
  } fill_t;

  typedef struct packed {
    dp_op_t      op;
    logic [1:0]  p_sel;
    logic [5:0]  key_idx;
    logic        mix_commit;
    fill_t       fill;
    logic [3:0]  s_addr;
    logic        dec;
    logic        out_zero;
  } rbf_cmd_t;

  typedef struct packed {
    logic [5:0] key_len;
    logic       out_free;
  } rbf_stat_t;

  // Modulo-3 step helpers for P indexes
  function automatic logic [1:0] mod3_inc(logic [1:0] v);
    return (v == 2'd2) ? 2'd0 : 2'(v + 2'd1);
  endfunction

  function automatic logic [1:0] mod3_dec(logic [1:0] v);
    return (v == 2'd0) ? 2'd2 : 2'(v - 2'd1);
  endfunction

endpackage

>>> rtl/core/rbf_ctrl.sv
// Controller for the reduced Blowfish cipher: request sequencing, round,
// key mixing and table refill counters. Depends on rbf_pkg.
module rbf_ctrl #(
  parameter int ROUNDS = rbf_pkg::DEF_ROUNDS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [1:0]         in_func,
  output logic               in_ready,
  input  rbf_pkg::rbf_stat_t st,
  output rbf_pkg::rbf_cmd_t  cmd
);
  import rbf_pkg::*;

  localparam int         RW          = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
  localparam logic [RW-1:0] RND_LAST = RW'(ROUNDS - 1);
  localparam logic [1:0] DEC_START   = 2'((ROUNDS + 1) % PBOX_WORDS);
  localparam logic [4:0] WORD_LAST   = 5'(MIX_WORDS - 1);
  localparam logic [6:0] PFILL_LAST  = 7'(MIX_WORDS / 2 - 1);
  localparam logic [6:0] SFILL_LAST  = 7'(S_FILL / 2 - 1);

  state_t        state_r, state_nxt;
  logic          dec_r, dec_nxt;
  logic          zero_r, zero_nxt;
  fill_t         fill_r, fill_nxt;
  logic [RW-1:0] rnd_r, rnd_nxt;
  logic [1:0]    pidx_r, pidx_nxt;
  logic [5:0]    j_r, j_nxt;
  logic [1:0]    byte_r, byte_nxt;
  logic [4:0]    word_r, word_nxt;
  logic [1:0]    pmix_r, pmix_nxt;
  logic [6:0]    fcnt_r, fcnt_nxt;
  logic [1:0]    fq_r, fq_nxt;

  // Next state and counters
  always_comb begin
    state_nxt = state_r;
    dec_nxt   = dec_r;
    zero_nxt  = zero_r;
    fill_nxt  = fill_r;
    rnd_nxt   = rnd_r;
    pidx_nxt  = pidx_r;
    j_nxt     = j_r;
    byte_nxt  = byte_r;
    word_nxt  = word_r;
    pmix_nxt  = pmix_r;
    fcnt_nxt  = fcnt_r;
    fq_nxt    = fq_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_func)
            FN_ENC, FN_DEC: begin
              state_nxt = ST_RA;
              dec_nxt   = (in_func == FN_DEC);
              zero_nxt  = 1'b0;
              fill_nxt  = FILL_NONE;
              rnd_nxt   = '0;
              pidx_nxt  = (in_func == FN_DEC) ? DEC_START : 2'd0;
            end
            FN_REKEY: begin
              state_nxt = ST_INIT;
              zero_nxt  = 1'b1;
            end
            default: begin
              state_nxt = ST_DONE;
              zero_nxt  = 1'b1;
            end
          endcase
        end
      end
      ST_INIT: begin
        j_nxt    = '0;
        byte_nxt = '0;
        word_nxt = '0;
        pmix_nxt = '0;
        if (st.key_len == 6'd0) begin
          state_nxt = ST_RA;
          fill_nxt  = FILL_P;
          fcnt_nxt  = '0;
          fq_nxt    = '0;
          rnd_nxt   = '0;
          pidx_nxt  = '0;
          dec_nxt   = 1'b0;
        end else begin
          state_nxt = ST_MIX;
        end
      end
      ST_MIX: begin
        // key byte index wraps at the key length
        j_nxt    = (7'(j_r) + 7'd1 == 7'(st.key_len)) ? 6'd0 : 6'(j_r + 6'd1);
        byte_nxt = 2'(byte_r + 2'd1);
        if (byte_r == 2'd3) begin
          pmix_nxt = mod3_inc(pmix_r);
          word_nxt = 5'(word_r + 5'd1);
          if (word_r == WORD_LAST) begin
            state_nxt = ST_RA;
            fill_nxt  = FILL_P;
            fcnt_nxt  = '0;
            fq_nxt    = '0;
            rnd_nxt   = '0;
            pidx_nxt  = '0;
            dec_nxt   = 1'b0;
          end
        end
      end
      ST_RA: state_nxt = ST_RB;
      ST_RB: state_nxt = ST_RC;
      ST_RC: begin
        pidx_nxt = dec_r ? mod3_dec(pidx_r) : mod3_inc(pidx_r);
        rnd_nxt  = RW'(rnd_r + 1'b1);
        state_nxt = (rnd_r == RND_LAST) ? ST_FIN : ST_RA;
      end
      ST_FIN: begin
        case (fill_r)
          FILL_P: begin
            state_nxt = ST_RA;
            rnd_nxt   = '0;
            pidx_nxt  = '0;
            fq_nxt    = mod3_inc(mod3_inc(fq_r));
            if (fcnt_r == PFILL_LAST) begin
              fill_nxt = FILL_S;
              fcnt_nxt = '0;
            end else begin
              fcnt_nxt = 7'(fcnt_r + 7'd1);
            end
          end
          FILL_S:  state_nxt = ST_SWR;
          default: state_nxt = ST_DONE;
        endcase
      end
      ST_SWR: begin
        if (fcnt_r == SFILL_LAST) begin
          state_nxt = ST_DONE;
          fill_nxt  = FILL_NONE;
        end else begin
          state_nxt = ST_RA;
          fcnt_nxt  = 7'(fcnt_r + 7'd1);
          rnd_nxt   = '0;
          pidx_nxt  = '0;
        end
      end
      ST_DONE: begin
        if (st.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    in_ready       = 1'b0;
    cmd.op         = DP_NOP;
    cmd.p_sel      = pidx_r;
    cmd.key_idx    = j_r;
    cmd.mix_commit = (byte_r == 2'd3);
    cmd.fill       = fill_r;
    // S refill index 2n mod 16 for hi, 2n+1 for lo
    cmd.s_addr     = {fcnt_r[2:0], (state_r == ST_SWR)};
    cmd.dec        = dec_r;
    cmd.out_zero   = zero_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && (in_func == FN_ENC || in_func == FN_DEC)) cmd.op = DP_LOAD;
      end
      ST_INIT: cmd.op = DP_REKEY_INIT;
      ST_MIX: begin
        cmd.op    = DP_MIX;
        cmd.p_sel = pmix_r;
      end
      ST_RA: cmd.op = DP_RND_A;
      ST_RB: cmd.op = DP_RND_B;
      ST_RC: cmd.op = DP_RND_C;
      ST_FIN: begin
        cmd.op    = DP_FIN;
        cmd.p_sel = fq_r;
      end
      ST_SWR: cmd.op = DP_SWR_LO;
      ST_DONE: begin
        if (st.out_free) cmd.op = DP_OUT;
      end
      default: cmd.op = DP_NOP;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      dec_r   <= 1'b0;
      zero_r  <= 1'b0;
      fill_r  <= FILL_NONE;
      rnd_r   <= '0;
      pidx_r  <= '0;
      j_r     <= '0;
      byte_r  <= '0;
      word_r  <= '0;
      pmix_r  <= '0;
      fcnt_r  <= '0;
      fq_r    <= '0;
    end else begin
      state_r <= state_nxt;
      dec_r   <= dec_nxt;
      zero_r  <= zero_nxt;
      fill_r  <= fill_nxt;
      rnd_r   <= rnd_nxt;
      pidx_r  <= pidx_nxt;
      j_r     <= j_nxt;
      byte_r  <= byte_nxt;
      word_r  <= word_nxt;
      pmix_r  <= pmix_nxt;
      fcnt_r  <= fcnt_nxt;
      fq_r    <= fq_nxt;
    end
  end

  // Checks
  a_mix_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MIX) |-> (j_r < st.key_len))
    else $error("key byte index beyond key length");

  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && !st.out_free) |=> (state_r == ST_DONE))
    else $error("result left while output register busy");

  a_pfill_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && fill_r == FILL_P) |-> (fcnt_r <= PFILL_LAST))
    else $error("P refill count out of range");

endmodule

>>> rtl/core/rbf_dpath.sv
// Datapath for the reduced Blowfish cipher: key registers, P words, S memory,
// Feistel round logic and output register. Depends on rbf_pkg.
module rbf_dpath #(
  parameter int ROUNDS = rbf_pkg::DEF_ROUNDS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic [31:0]        in_block_hi,
  input  logic [31:0]        in_block_lo,
  input  rbf_pkg::rbf_cmd_t  cmd,
  output rbf_pkg::rbf_stat_t st,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [31:0]        out_hi,
  output logic [31:0]        out_lo
);
  import rbf_pkg::*;

  // final whitening P indexes on encrypt
  localparam logic [1:0] WH = 2'((ROUNDS + 1) % PBOX_WORDS);
  localparam logic [1:0] WL = 2'(ROUNDS % PBOX_WORDS);

  logic [5:0]  key_len_r;
  logic [63:0] key_r [KEY_REGS];
  logic [31:0] p_r   [PBOX_WORDS];
  logic [31:0] p_nxt [PBOX_WORDS];
  logic [31:0] h_r, h_nxt, l_r, l_nxt, acc_r, acc_nxt;
  logic [23:0] w_r, w_nxt;

  logic [31:0] s_mem [SBOX_WORDS];
  logic [15:0] s_vld_r;
  logic [31:0] q0_r, q1_r;
  logic        qv0_r, qv1_r;
  logic [3:0]  qa0_r, qa1_r;
  logic [3:0]  ra0, ra1;
  logic        s_we;
  logic [31:0] s_wd;
  logic [31:0] s0, s1;

  logic        out_valid_r;
  logic [31:0] out_hi_r, out_lo_r;

  logic [5:0]  key_len_mod;
  logic [63:0] key_word;
  logic [7:0]  key_byte;
  logic [31:0] h_x, f_val, wo_hi, wo_lo;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_len_r <= '0;
      for (int i = 0; i < KEY_REGS; i++) key_r[i] <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_KEY_LEN) key_len_r <= cfg_data[5:0];
      else key_r[3'(cfg_index - CFG_KEY_FIRST)] <= cfg_data;
    end
  end

  // Key length modulo 57
  assign key_len_mod = (key_len_r >= 6'(KEY_MOD)) ? 6'(key_len_r - 6'(KEY_MOD)) : key_len_r;

  // Key byte pick, first byte most significant
  assign key_word = (cmd.key_idx[5:3] < 3'(KEY_REGS)) ? key_r[cmd.key_idx[5:3]] : '0;
  assign key_byte = key_word[{~cmd.key_idx[2:0], 3'b000} +: 8];

  // S read data: unwritten entries read as their initial words
  assign s0 = qv0_r ? q0_r : INIT_S[qa0_r];
  assign s1 = qv1_r ? q1_r : INIT_S[qa1_r];

  // Round and whitening terms
  assign h_x   = h_r ^ p_r[cmd.p_sel];
  assign f_val = (acc_r ^ s0) + s1;
  assign wo_hi = l_r ^ (cmd.dec ? p_r[0] : p_r[WH]);
  assign wo_lo = h_r ^ (cmd.dec ? p_r[1] : p_r[WL]);

  // S read addresses: bytes 3 and 2 in first step, bytes 1 and 0 in second
  always_comb begin
    ra0 = '0;
    ra1 = '0;
    case (cmd.op)
      DP_RND_A: begin
        ra0 = h_x[27:24];
        ra1 = h_x[19:16];
      end
      DP_RND_B: begin
        ra0 = h_r[11:8];
        ra1 = h_r[3:0];
      end
      default: ;
    endcase
  end

  assign s_we = (cmd.op == DP_FIN && cmd.fill == FILL_S) || (cmd.op == DP_SWR_LO);
  assign s_wd = (cmd.op == DP_SWR_LO) ? l_r : wo_hi;

  // Block, accumulator, mixing word and P updates
  always_comb begin
    h_nxt   = h_r;
    l_nxt   = l_r;
    acc_nxt = acc_r;
    w_nxt   = w_r;
    p_nxt   = p_r;
    case (cmd.op)
      DP_LOAD: begin
        h_nxt = in_block_hi;
        l_nxt = in_block_lo;
      end
      DP_REKEY_INIT: begin
        h_nxt = '0;
        l_nxt = '0;
        w_nxt = '0;
        p_nxt = INIT_P;
      end
      DP_MIX: begin
        w_nxt = {w_r[15:0], key_byte};
        if (cmd.mix_commit) p_nxt[cmd.p_sel] = p_r[cmd.p_sel] ^ {w_r, key_byte};
      end
      DP_RND_A: h_nxt = h_x;
      DP_RND_B: acc_nxt = s0 + s1;
      DP_RND_C: begin
        h_nxt = l_r ^ f_val;
        l_nxt = h_r;
      end
      DP_FIN: begin
        h_nxt = wo_hi;
        l_nxt = wo_lo;
        if (cmd.fill == FILL_P) begin
          p_nxt[cmd.p_sel]           = wo_hi;
          p_nxt[mod3_inc(cmd.p_sel)] = wo_lo;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r <= INIT_P;
    end else begin
      p_r <= p_nxt;
    end
  end

  always_ff @(posedge clk) begin
    h_r   <= h_nxt;
    l_r   <= l_nxt;
    acc_r <= acc_nxt;
    w_r   <= w_nxt;
  end

  // S memory, two registered read ports, one write port
  always_ff @(posedge clk) begin
    if (s_we) s_mem[cmd.s_addr] <= s_wd;
    q0_r  <= s_mem[ra0];
    q1_r  <= s_mem[ra1];
    qv0_r <= s_vld_r[ra0];
    qv1_r <= s_vld_r[ra1];
    qa0_r <= ra0;
    qa1_r <= ra1;
  end

  // S valid bits: cleared by reset and at rekey start
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= '0;
    end else if (cmd.op == DP_REKEY_INIT) begin
      s_vld_r <= '0;
    end else if (s_we) begin
      s_vld_r[cmd.s_addr] <= 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == DP_OUT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_OUT) begin
      out_hi_r <= cmd.out_zero ? '0 : h_r;
      out_lo_r <= cmd.out_zero ? '0 : l_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_hi      = out_hi_r;
  assign out_lo      = out_lo_r;
  assign st.key_len  = key_len_mod;
  assign st.out_free = !out_valid_r || out_ready;

  // Checks
  a_vld_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == DP_REKEY_INIT) |=> (s_vld_r == '0))
    else $error("S valid bits not cleared at rekey");

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == DP_OUT) |-> (!out_valid_r || out_ready))
    else $error("result overwrote a waiting result");

  a_p_sel: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == DP_RND_A || cmd.op == DP_MIX || cmd.op == DP_FIN) |-> (cmd.p_sel != 2'd3))
    else $error("P index out of range");

endmodule

>>> rtl/core/reduced_blowfish_cipher.sv
// Top level of the reduced Blowfish cipher: controller plus datapath.
// Depends on rbf_pkg, rbf_ctrl and rbf_dpath.
//
// Reduced Blowfish with a 3-word P table and a 16-word S table. Each request
// is a rekey (func 0), an encrypt (1) or a decrypt (2) of a 64-bit block, and
// gives one result; rekey and func 3 return zero. One request is worked on at
// a time. A Feistel round is paced by the S memory's two registered read
// ports (two S reads, then two more, then the F sum and half swap). A rekey
// runs key mixing (none at key length zero), then the P refill and the S
// refill by chained encryptions, with two S words written per encryption. The
// next request is taken while a result still waits in the output register.
// Configuration writes are taken at once and must only be made while the
// block is idle.
module reduced_blowfish_cipher #(
  parameter int ROUNDS = rbf_pkg::DEF_ROUNDS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_block_hi,
  input  logic [31:0] in_block_lo,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_hi,
  output logic [31:0] out_lo
);
  import rbf_pkg::*;

  rbf_cmd_t  cmd;
  rbf_stat_t st;

  rbf_ctrl #(
    .ROUNDS (ROUNDS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  rbf_dpath #(
    .ROUNDS (ROUNDS)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_block_hi (in_block_hi),
    .in_block_lo (in_block_lo),
    .cmd         (cmd),
    .st          (st),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .out_hi      (out_hi),
    .out_lo      (out_lo)
  );

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// Testbench for reduced_blowfish_cipher: directed and random requests against a
// shadow copy of the P/S tables and key registers. Depends on rbf_pkg and the RTL.
module testbench;
  import rbf_pkg::*;

  typedef struct packed {
    logic [31:0] hi;
    logic [31:0] lo;
  } block_t;

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int RANDOM_ITEMS = 1130;
  localparam int PHASES       = 6;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 60;

  // Shadow of the cipher state plus the queue of blocks still owed by the block
  class cipher_shadow;
    logic [31:0] p_word [PBOX_WORDS];
    logic [31:0] s_word [SBOX_WORDS];
    logic [5:0]  key_len;
    logic [63:0] key_reg [KEY_REGS];
    block_t      owed_blocks [$];
    block_t      last_cipher;
    int          errors;

    function new();
      for (int i = 0; i < PBOX_WORDS; i++) p_word[i] = INIT_P[i];
      for (int i = 0; i < SBOX_WORDS; i++) s_word[i] = INIT_S[i];
      for (int i = 0; i < KEY_REGS; i++) key_reg[i] = '0;
      key_len     = '0;
      last_cipher = '0;
      errors      = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] val);
      if (idx == CFG_KEY_LEN) begin
        key_len = val[5:0];
      end else if (idx >= CFG_KEY_FIRST && idx < CFG_KEY_FIRST + KEY_REGS) begin
        key_reg[idx - CFG_KEY_FIRST] = val;
      end
    endfunction

    // Sixteen Feistel rounds; decrypt walks the P table backwards
    function void feistel_pass(inout block_t b, input bit dec);
      logic [31:0] h, l, t, fx;
      int idx;
      h = b.hi;
      l = b.lo;
      for (int r = 0; r < DEF_ROUNDS; r++) begin
        idx = dec ? (DEF_ROUNDS + 1 - r) : r;
        h ^= p_word[idx % PBOX_WORDS];
        fx = ((s_word[h[27:24]] + s_word[h[19:16]]) ^ s_word[h[11:8]]) + s_word[h[3:0]];
        l ^= fx;
        t = h; h = l; l = t;
      end
      t = h; h = l; l = t;
      if (dec) begin
        l ^= p_word[1 % PBOX_WORDS];
        h ^= p_word[0];
      end else begin
        l ^= p_word[DEF_ROUNDS % PBOX_WORDS];
        h ^= p_word[(DEF_ROUNDS + 1) % PBOX_WORDS];
      end
      b.hi = h;
      b.lo = l;
    endfunction

    function void note_request(logic [1:0] fn, block_t data);
      block_t res;
      int len, j;
      logic [31:0] w;
      res = data;
      case (fn)
        FN_ENC: begin
          feistel_pass(res, 1'b0);
          last_cipher = res;
        end
        FN_DEC: feistel_pass(res, 1'b1);
        FN_REKEY: begin
          len = key_len % KEY_MOD;
          for (int i = 0; i < PBOX_WORDS; i++) p_word[i] = INIT_P[i];
          for (int i = 0; i < SBOX_WORDS; i++) s_word[i] = INIT_S[i];
          // cyclic key bytes, four to a word, folded into P
          if (len != 0) begin
            j = 0;
            for (int i = 0; i < MIX_WORDS; i++) begin
              w = '0;
              for (int k = 0; k < 4; k++) begin
                w = {w[23:0], key_reg[j / 8][63 - 8 * (j % 8) -: 8]};
                j++;
                if (j == len) j = 0;
              end
              p_word[i % PBOX_WORDS] ^= w;
            end
          end
          // chained encryptions of zero refill P, then S
          res = '0;
          for (int i = 0; i < MIX_WORDS; i += 2) begin
            feistel_pass(res, 1'b0);
            p_word[i % PBOX_WORDS]       = res.hi;
            p_word[(i + 1) % PBOX_WORDS] = res.lo;
          end
          for (int i = 0; i < S_FILL; i += 2) begin
            feistel_pass(res, 1'b0);
            s_word[i % SBOX_WORDS]       = res.hi;
            s_word[(i + 1) % SBOX_WORDS] = res.lo;
          end
          res = '0;
        end
        default: res = '0;
      endcase
      owed_blocks.push_back(res);
    endfunction

    function void check_result(block_t got);
      block_t want;
      if (owed_blocks.size() == 0) begin
        $error("result with no request outstanding: out_hi %h out_lo %h", got.hi, got.lo);
        errors++;
        return;
      end
      want = owed_blocks.pop_front();
      if (got.hi !== want.hi) begin
        $error("out_hi: expected %h, got %h", want.hi, got.hi);
        errors++;
      end
      if (got.lo !== want.lo) begin
        $error("out_lo: expected %h, got %h", want.lo, got.lo);
        errors++;
      end
    endfunction

    function int pending();
      return owed_blocks.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_func = '0;
  logic [31:0] in_block_hi = '0;
  logic [31:0] in_block_lo = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_hi;
  logic [31:0] out_lo;

  int tx_idle_pct = 31;
  int rx_idle_pct = 31;
  bit rx_hold_req = 1'b0;
  bit rx_hold_taken = 1'b0;
  int rx_hold_left = 0;
  int cycle_count = 0;

  cipher_shadow shadow;

  reduced_blowfish_cipher #(.ROUNDS(DEF_ROUNDS)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_func     (in_func),
    .in_block_hi (in_block_hi),
    .in_block_lo (in_block_lo),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_hi      (out_hi),
    .out_lo      (out_lo)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (rx_hold_req && !rx_hold_taken) begin
      rx_hold_taken = 1'b1;
      rx_hold_left  = HOLD_CYCLES;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) shadow.check_result(block_t'({out_hi, out_lo}));
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Offer one request, idling first at random; valid stays high afterwards
  task automatic send_request(logic [1:0] fn, block_t data);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_func     <= fn;
    in_block_hi <= data.hi;
    in_block_lo <= data.lo;
    do @(posedge clk); while (in_ready !== 1'b1);
    shadow.note_request(fn, data);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (shadow.pending() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Key registers may only change once the block has nothing in flight
  task automatic load_key(logic [5:0] len, bit ones);
    logic [63:0] val;
    wait_idle();
    for (int i = 0; i <= KEY_REGS; i++) begin
      if (i == 0) val = {$urandom, 26'($urandom), len};
      else val = ones ? '1 : {$urandom, $urandom};
      if (i == 0) val[5:0] = len;
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= CFG_KEY_LEN + 3'(i);
      cfg_data  <= val;
      shadow.write_reg(CFG_KEY_LEN + 3'(i), val);
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_request();
    int r;
    r = $urandom_range(199);
    if (r < 3) begin
      send_request(FN_REKEY, {pick_word(), pick_word()});
    end else if (r < 13) begin
      send_request(FN_NONE, {pick_word(), pick_word()});
    end else if (r < 105) begin
      send_request(FN_ENC, {pick_word(), pick_word()});
    end else if ($urandom_range(2) == 0) begin
      // round trip of the last ciphertext
      send_request(FN_DEC, shadow.last_cipher);
    end else begin
      send_request(FN_DEC, {pick_word(), pick_word()});
    end
  endtask

  initial begin
    logic [5:0] len;
    shadow = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset tables first, then rekeys at the key length extremes
    send_request(FN_ENC, {32'h0, 32'h0});
    send_request(FN_ENC, {32'hFFFFFFFF, 32'hFFFFFFFF});
    send_request(FN_DEC, {32'h0, 32'h0});
    send_request(FN_DEC, {32'hFFFFFFFF, 32'hFFFFFFFF});
    send_request(FN_NONE, {pick_word(), pick_word()});
    send_request(FN_ENC, {32'h0, 32'hFFFFFFFF});
    send_request(FN_REKEY, {32'hFFFFFFFF, 32'h0});
    send_request(FN_ENC, {32'h0, 32'h0});
    send_request(FN_DEC, shadow.last_cipher);
    load_key(6'd56, 1'b0);
    send_request(FN_REKEY, {pick_word(), pick_word()});
    send_request(FN_ENC, {32'hFFFFFFFF, 32'h0});
    send_request(FN_DEC, shadow.last_cipher);
    load_key(6'd63, 1'b1);
    send_request(FN_REKEY, {pick_word(), pick_word()});
    send_request(FN_ENC, {pick_word(), pick_word()});
    load_key(6'd57, 1'b0);
    send_request(FN_REKEY, {pick_word(), pick_word()});
    send_request(FN_ENC, {pick_word(), pick_word()});
    send_request(FN_NONE, {32'hFFFFFFFF, 32'hFFFFFFFF});
    load_key(6'd1, 1'b1);
    send_request(FN_REKEY, {pick_word(), pick_word()});
    send_request(FN_ENC, {pick_word(), pick_word()});

    // Random phases, each opening with a fresh key and a rekey
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: len = 6'd56;
        1: len = 6'd0;
        2: len = 6'(KEY_MOD + $urandom_range(6));
        3: len = 6'($urandom_range(1, 55));
        default: len = 6'($urandom_range(63));
      endcase
      load_key(len, ph == 4);
      tx_idle_pct = (ph == 2) ? 0 : 31;
      rx_idle_pct = (ph == 2) ? 0 : 31;
      send_request(FN_REKEY, {pick_word(), pick_word()});
      for (int n = 1; n < RANDOM_ITEMS / PHASES; n++) begin
        if (ph == 3 && n == 20) rx_hold_req = 1'b1;
        random_request();
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (shadow.errors == 0 && shadow.pending() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
